@@ hdl/dcpe_pkg.sv @@
`default_nettype none

package dcpe_pkg;

	// Register map of the configuration port
	typedef enum logic [1:0] {
		REG_GATE  = 2'd0,
		REG_LIMIT = 2'd1,
		REG_NUMER = 2'd2
	} cfg_idx_t;

	localparam int unsigned GATE_W  = 15;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned NUMER_W = 7;
	localparam int unsigned CFG_W   = 15;

	localparam logic [GATE_W-1:0]  GATE_RST  = 15'd500;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd25000;
	localparam logic [NUMER_W-1:0] NUMER_RST = 7'd97;

	// floor(n/100) for n < 2^18: (n * DC_RECIP) >> DC_SHIFT
	localparam logic [17:0]        DC_OFFSET = 18'd65600;
	localparam logic signed [11:0] DC_BIAS   = 12'sd656;
	localparam logic [18:0]        DC_RECIP  = 19'd335545;
	localparam int unsigned        DC_SHIFT  = 25;

	// floor(a/100) for a < 2^22: (a * EMPH_RECIP) >> EMPH_SHIFT
	localparam logic [21:0]        EMPH_RECIP = 22'd2684355;
	localparam int unsigned        EMPH_SHIFT = 28;

	typedef struct packed {
		logic [GATE_W-1:0]  gate;
		logic [LIMIT_W-1:0] limit;
		logic [NUMER_W-1:0] numer;
	} cfg_t;

	// DC stage result: corrected sample and previous sample times numerator
	typedef struct packed {
		logic signed [15:0] d;
		logic signed [22:0] m;
	} dc_link_t;

endpackage

`default_nettype wire

@@ hdl/dcpe_dc_stage.sv @@
`default_nettype none

module dcpe_dc_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load_s1,
	input  wire logic                 adv_s2,
	input  wire logic signed [15:0]   sample_in,
	input  wire dcpe_pkg::cfg_t       cfg,
	output dcpe_pkg::dc_link_t        link_s2
);

	logic signed [15:0] x_s1;
	logic signed [15:0] avg_q;
	logic signed [15:0] prev_q;
	logic signed [16:0] diff;
	logic [17:0]        num_off;
	logic [36:0]        recip_prod;
	logic signed [11:0] quo;
	logic               exact;
	logic signed [16:0] sum;
	logic signed [16:0] avg_wide;
	logic signed [15:0] avg_next;
	logic signed [15:0] dc_out;
	logic signed [22:0] emph_prod;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			x_s1 <= sample_in;
		end
	end

	// avg' = trunc0(avg + (x - avg)/100), built from a floor division of x - avg
	always_comb begin
		diff       = 17'(x_s1) - 17'(avg_q);
		num_off    = 18'(diff) + dcpe_pkg::DC_OFFSET;
		recip_prod = 37'(num_off) * 37'(dcpe_pkg::DC_RECIP);
		quo        = 12'($signed(recip_prod[36:dcpe_pkg::DC_SHIFT]) - dcpe_pkg::DC_BIAS);
		exact      = (recip_prod[dcpe_pkg::DC_SHIFT-1:18] == '0);
		sum        = 17'(avg_q) + 17'(quo);
		// round a negative inexact quotient up toward zero
		avg_wide   = (!exact && sum[16]) ? (sum + 17'sd1) : sum;
		avg_next   = avg_wide[15:0];
		dc_out     = x_s1 - (avg_next >>> 8);
		emph_prod  = 23'(prev_q) * 23'($signed({1'b0, cfg.numer}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q  <= '0;
			prev_q <= '0;
		end else if (adv_s2) begin
			avg_q  <= avg_next;
			prev_q <= dc_out;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			link_s2.d <= dc_out;
			link_s2.m <= emph_prod;
		end
	end

endmodule

`default_nettype wire

@@ hdl/dcpe_emph_stage.sv @@
`default_nettype none

module dcpe_emph_stage (
	input  wire logic                 clk,
	input  wire logic                 adv_s3,
	input  wire dcpe_pkg::dc_link_t   link_s2,
	output logic signed [17:0]        filt_s3
);

	logic               neg;
	logic [21:0]        mag;
	logic [43:0]        recip_prod;
	logic [15:0]        quo_mag;
	logic signed [17:0] quo;
	logic signed [17:0] filt;

	// trunc0(m / 100) by magnitude, then restore the sign
	always_comb begin
		neg        = link_s2.m[22];
		mag        = 22'(neg ? -link_s2.m : link_s2.m);
		recip_prod = 44'(mag) * 44'(dcpe_pkg::EMPH_RECIP);
		quo_mag    = recip_prod[43:dcpe_pkg::EMPH_SHIFT];
		quo        = $signed({2'b00, quo_mag});
		if (neg) begin
			quo = -quo;
		end
		filt       = 18'(link_s2.d) - quo;
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			filt_s3 <= filt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/dcpe_gain_stage.sv @@
`default_nettype none

module dcpe_gain_stage (
	input  wire logic                 clk,
	input  wire logic                 adv_s4,
	input  wire logic signed [17:0]   filt_s3,
	input  wire dcpe_pkg::cfg_t       cfg,
	output logic signed [15:0]        sample_out
);

	function automatic logic signed [19:0] clip_sym(
		input logic signed [19:0] v,
		input logic signed [19:0] lim
	);
		logic signed [19:0] r;
		r = v;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	logic [16:0]        mag;
	logic               gated;
	logic signed [19:0] trip;
	logic signed [19:0] half;
	logic signed [19:0] lim;
	logic signed [19:0] stage1;
	logic signed [19:0] stage2;
	logic signed [15:0] result;

	always_comb begin
		mag    = 17'(filt_s3[17] ? -filt_s3 : filt_s3);
		gated  = (mag < 17'(cfg.gate));
		trip   = 20'(filt_s3) * 20'sd3;
		// truncate toward zero on the halving
		half   = (trip + $signed({19'd0, trip[19]})) >>> 1;
		lim    = $signed(20'(cfg.limit));
		stage1 = clip_sym(half, lim);
		stage2 = clip_sym(stage1 <<< 1, lim);
		result = gated ? 16'sd0 : stage2[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			sample_out <= result;
		end
	end

endmodule

`default_nettype wire

@@ hdl/audio_dc_preemphasis_gate_chain.sv @@
// Audio conditioning chain: DC tracking, pre-emphasis, noise gate and two
// saturating gain stages on a stream of signed 16-bit samples.
// Input channel: sample_in with in_valid/in_stall; a transaction completes at
// a rising edge with in_valid high and in_stall low. Output channel:
// sample_out with out_valid/out_stall, same rule. One result per sample.
// Path: a sample taken into the input register moves through the DC stage,
// pre-emphasis divide and gain/clip output registers to sample_out.
// Throughput: one sample per cycle unless out_stall holds it; the recurrences
// on the DC average and the previous sample each close in one register stage.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 gate threshold,
// 1 clip limit, 2 emphasis numerator) and cfg_data; cfg_ready is always high,
// unknown indexes are dropped. Write only while the chain is drained.
// Reset (arst_n low) clears the DC average, the previous sample, all stage
// valids, and loads the default gate, limit and numerator.
// Stall: a held result keeps sample_out stable; empty stages ahead of it keep
// filling, and in_stall rises only once every stage holds a sample.

`default_nettype none

module audio_dc_preemphasis_gate_chain (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [15:0]              sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [15:0]                   sample_out,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [dcpe_pkg::CFG_W-1:0]      cfg_data
);

	dcpe_pkg::cfg_t     cfg_q;
	dcpe_pkg::dc_link_t link_s2;
	logic signed [17:0] filt_s3;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic load_s1, adv_s2, adv_s3, adv_s4;

	assign cfg_ready = 1'b1;

	// Configuration registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate  <= dcpe_pkg::GATE_RST;
			cfg_q.limit <= dcpe_pkg::LIMIT_RST;
			cfg_q.numer <= dcpe_pkg::NUMER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (dcpe_pkg::cfg_idx_t'(cfg_index))
				dcpe_pkg::REG_GATE:  cfg_q.gate  <= cfg_data[dcpe_pkg::GATE_W-1:0];
				dcpe_pkg::REG_LIMIT: cfg_q.limit <= cfg_data[dcpe_pkg::LIMIT_W-1:0];
				dcpe_pkg::REG_NUMER: cfg_q.numer <= cfg_data[dcpe_pkg::NUMER_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances
	always_comb begin
		en_s4    = !valid_s4 || !out_stall;
		en_s3    = !valid_s3 || en_s4;
		en_s2    = !valid_s2 || en_s3;
		en_s1    = !valid_s1 || en_s2;
		in_stall = !en_s1;
		load_s1  = in_valid && en_s1;
		adv_s2   = valid_s1 && en_s2;
		adv_s3   = valid_s2 && en_s3;
		adv_s4   = valid_s3 && en_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign out_valid = valid_s4;

	dcpe_dc_stage u_dc (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_s1   (load_s1),
		.adv_s2    (adv_s2),
		.sample_in (sample_in),
		.cfg       (cfg_q),
		.link_s2   (link_s2)
	);

	dcpe_emph_stage u_emph (
		.clk     (clk),
		.adv_s3  (adv_s3),
		.link_s2 (link_s2),
		.filt_s3 (filt_s3)
	);

	dcpe_gain_stage u_gain (
		.clk        (clk),
		.adv_s4     (adv_s4),
		.filt_s3    (filt_s3),
		.cfg        (cfg_q),
		.sample_out (sample_out)
	);

endmodule

`default_nettype wire

@@ hdl/dcpe_checker.sv @@
`default_nettype none

module dcpe_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] sample_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed");

	// input backpressure only comes from a blocked output
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while output free");

	// symmetric clipping never reaches the most negative code
	a_clip_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_out != 16'sh8000)
		else $error("result outside clip range");

endmodule

bind audio_dc_preemphasis_gate_chain dcpe_checker u_dcpe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out)
);

`default_nettype wire

@@ test/audio_dc_preemphasis_gate_chain_tb.sv @@
`default_nettype none

module audio_dc_preemphasis_gate_chain_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HIGH      = 6;
	localparam int CLK_LOW       = 6;
	localparam int RESET_CYCLES  = 8;
	localparam int RANDOM_ITEMS  = 1200;
	// The chain is four register stages deep; settle() adds a margin after draining.
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_CAP     = 30;

	// Index past the end of the register map; the block must drop the write.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic {
		ROW_WRITE,
		ROW_SAMPLE
	} row_kind_t;

	// One line of the directed table: either a register write or a sample,
	// with an optional hand-typed result.
	typedef struct {
		row_kind_t                  kind;
		logic [1:0]                 idx;
		logic [dcpe_pkg::CFG_W-1:0] data;
		logic signed [15:0]         x;
		bit                         fixed;
		logic signed [15:0]         want;
	} dir_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [15:0]                sample_in = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [15:0]                sample_out;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [1:0]                        cfg_index = '0;
	logic [dcpe_pkg::CFG_W-1:0]        cfg_data = '0;

	// Shadow copy of the chain's state and registers
	logic signed [15:0]                dc_avg;
	logic signed [15:0]                prev_d;
	logic [dcpe_pkg::GATE_W-1:0]       gate_q;
	logic [dcpe_pkg::LIMIT_W-1:0]      limit_q;
	logic [dcpe_pkg::NUMER_W-1:0]      numer_q;

	// Conditioned samples still owed by the block, oldest first
	logic signed [15:0]      conditioned_q[$];
	dir_row_t                dir_rows[$];

	int cycle_count    = 0;
	int mismatch_count = 0;
	int results_seen   = 0;
	int nonzero_seen   = 0;
	int dir_sent       = 0;
	int rand_sent      = 0;
	int reg_writes     = 0;
	int settings_seen  = 0;
	int burst_left     = 0;
	int stall_mode     = 0;
	int stall_run      = 0;

	audio_dc_preemphasis_gate_chain u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// Symmetric saturation to +/- lim
	function automatic int clip_to(input int v, input int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Advance the shadow chain by one sample and return the conditioned result.
	function automatic logic signed [15:0] condition_sample(input logic signed [15:0] x);
		int                 xi;
		int                 avg;
		int                 d;
		int                 f;
		int                 mag;
		int                 r;
		int                 lim;
		int                 gate;
		int                 numer;
		logic signed [15:0] d16;
		xi    = int'(x);
		lim   = int'(limit_q);
		gate  = int'(gate_q);
		numer = int'(numer_q);
		// DC tracker: divide truncates toward zero, the shift floors
		avg    = (99 * int'(dc_avg) + xi) / 100;
		dc_avg = avg[15:0];
		d16    = 16'(xi - (avg >>> 8));
		d      = int'(d16);
		// Pre-emphasis against the previous DC-stage output
		f      = d - (int'(prev_d) * numer) / 100;
		prev_d = d16;
		mag    = (f < 0) ? -f : f;
		if (mag < gate) begin
			r = 0;
		end else begin
			r = clip_to((f * 3) / 2, lim);
			r = clip_to(r * 2, lim);
		end
		return r[15:0];
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Hold the transaction until the block takes it, then predict and optionally
	// go quiet for a while before the next burst.
	task automatic send_sample(input logic signed [15:0] x, input bit fixed,
			input logic signed [15:0] want);
		logic signed [15:0] predicted;
		int                 gap;
		sample_in <= x;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predicted = condition_sample(x);
		conditioned_q.push_back(fixed ? want : predicted);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			// Roughly a third of the bursts run back to back with no gap
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid, wait for every owed result, then let the pipe go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (conditioned_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register transaction; mirror it into the shadow registers.
	task automatic write_reg(input logic [1:0] idx, input logic [dcpe_pkg::CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dcpe_pkg::REG_GATE:  gate_q  = data[dcpe_pkg::GATE_W-1:0];
			dcpe_pkg::REG_LIMIT: limit_q = data[dcpe_pkg::LIMIT_W-1:0];
			dcpe_pkg::REG_NUMER: numer_q = data[dcpe_pkg::NUMER_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [dcpe_pkg::CFG_W-1:0] data);
		dir_row_t row;
		row = '{ROW_WRITE, idx, data, 16'sd0, 1'b0, 16'sd0};
		dir_rows.push_back(row);
	endtask

	task automatic add_sample(input logic signed [15:0] x, input bit fixed = 1'b0,
			input logic signed [15:0] want = 16'sd0);
		dir_row_t row;
		row = '{ROW_SAMPLE, REG_UNUSED, '0, x, fixed, want};
		dir_rows.push_back(row);
	endtask

	// Pick a fresh register setting, leaning on the extremes.
	task automatic shuffle_settings();
		logic [dcpe_pkg::CFG_W-1:0] g;
		logic [dcpe_pkg::CFG_W-1:0] l;
		logic [dcpe_pkg::CFG_W-1:0] n;
		case ($urandom_range(0, 4))
			0: g = '0;
			1: g = '1;
			2: g = 15'($urandom_range(0, 2000));
			3: g = 15'($urandom);
			default: g = 15'd500;
		endcase
		case ($urandom_range(0, 7))
			0: l = '0;
			1: l = '1;
			2, 3, 4: l = 15'($urandom_range(1, 32767));
			default: l = 15'($urandom_range(10000, 32767));
		endcase
		// Upper bits of the numerator transaction are noise the block must drop
		n = 15'($urandom);
		case ($urandom_range(0, 4))
			0: n[dcpe_pkg::NUMER_W-1:0] = 7'd0;
			1: n[dcpe_pkg::NUMER_W-1:0] = 7'd100;
			2: n[dcpe_pkg::NUMER_W-1:0] = 7'd127;
			default: ;
		endcase
		write_reg(dcpe_pkg::REG_GATE, g);
		write_reg(dcpe_pkg::REG_LIMIT, l);
		write_reg(dcpe_pkg::REG_NUMER, n);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, 15'($urandom));
		settings_seen++;
	endtask

	// Mix of full-range noise, rail hits, quiet signal, jitter around a DC offset
	// and large swings of random sign.
	function automatic logic signed [15:0] pick_sample(input int dc_bias);
		logic signed [15:0] r;
		int                 v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r = 16'($urandom);
			4, 5: begin
				case ($urandom_range(0, 3))
					0: r = 16'sh7FFF;
					1: r = 16'sh8000;
					2: r = 16'sh8001;
					default: r = 16'sd0;
				endcase
			end
			6, 7: begin
				v = int'($urandom_range(0, 4000)) - 2000;
				r = v[15:0];
			end
			8: begin
				v = dc_bias + int'($urandom_range(0, 1000)) - 500;
				r = v[15:0];
			end
			default: begin
				v = int'($urandom_range(16000, 32767));
				if ($urandom_range(0, 1) == 0)
					v = -v;
				r = v[15:0];
			end
		endcase
		return r;
	endfunction

	// Check each completed output transaction against the oldest owed result.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (conditioned_q.size() == 0) begin
				flag_mismatch($sformatf("sample_out %0d with no sample pending", sample_out));
			end else begin
				want = conditioned_q.pop_front();
				results_seen++;
				if (want != 0)
					nonzero_seen++;
				if (sample_out !== want)
					flag_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
						results_seen, sample_out, want));
			end
		end
	end

	// Receiver back-pressure: switch between free-running, light, heavy and
	// periodic stall, each mode held for a random run.
	always @(posedge clk) begin
		bit hold;
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(20, 150);
		end
		stall_run--;
		case (stall_mode)
			0: hold = 1'b0;
			1: hold = ($urandom_range(0, 3) == 0);
			2: hold = ($urandom_range(0, 3) != 0);
			default: hold = ((cycle_count % 3) == 2);
		endcase
		out_stall <= hold;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results owed", cycle_count,
				conditioned_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		int       phase_len;
		int       dc_bias;

		// Shadow state matches the block after reset
		dc_avg  = '0;
		prev_d  = '0;
		gate_q  = dcpe_pkg::GATE_RST;
		limit_q = dcpe_pkg::LIMIT_RST;
		numer_q = dcpe_pkg::NUMER_RST;

		// Directed table. Silence straight out of reset and anything under a
		// zero clip limit must come out as zero; the rest goes to the predictor.
		add_sample(16'sd0, 1'b1, 16'sd0);
		add_sample(16'sh7FFF);
		add_sample(16'sh8000);
		add_sample(16'sh7FFF);
		add_sample(16'sh8000);
		add_sample(16'sd300);
		add_sample(-16'sd300);
		// Zero gate: nothing is squelched
		add_write(dcpe_pkg::REG_GATE, 15'd0);
		add_sample(16'sd5);
		add_sample(-16'sd5);
		add_sample(16'sd0);
		// Coefficient of exactly one
		add_write(dcpe_pkg::REG_NUMER, 15'd100);
		add_sample(16'sd20000);
		add_sample(-16'sd20000);
		// All-ones data: numerator keeps its low 7 bits, coefficient above one
		add_write(dcpe_pkg::REG_NUMER, 15'h7FFF);
		add_sample(16'sh7FFF);
		add_sample(16'sh8000);
		add_sample(16'sh7FFF);
		// Out-of-range index must leave every register alone
		add_write(REG_UNUSED, 15'h7FFF);
		add_sample(16'sh8000);
		// Zero clip limit: both gain stages pin to zero
		add_write(dcpe_pkg::REG_LIMIT, 15'd0);
		add_sample(16'sh7FFF, 1'b1, 16'sd0);
		add_sample(16'sh8000, 1'b1, 16'sd0);
		add_sample(16'sd12345, 1'b1, 16'sd0);
		// Widest limit and widest gate
		add_write(dcpe_pkg::REG_LIMIT, 15'h7FFF);
		add_write(dcpe_pkg::REG_GATE, 15'h7FFF);
		add_sample(16'sh8000);
		add_sample(16'sh7FFF);
		add_sample(16'sd100);

		// Hold reset, then release it away from the rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				send_sample(row.x, row.fixed, row.want);
				dir_sent++;
			end
		end

		// Random phases, each under its own register setting
		while (rand_sent < RANDOM_ITEMS) begin
			settle();
			shuffle_settings();
			phase_len = $urandom_range(60, 180);
			dc_bias   = int'($urandom_range(0, 60000)) - 30000;
			repeat (phase_len) begin
				send_sample(pick_sample(dc_bias), 1'b0, 16'sd0);
				rand_sent++;
			end
		end
		settle();

		$display("Ran %0d directed and %0d random samples through %0d random settings (%0d writes).",
			dir_sent, rand_sent, settings_seen, reg_writes);
		$display("Checked %0d results, %0d of them nonzero, in %0d cycles.",
			results_seen, nonzero_seen, cycle_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/dcpe_pkg.sv
hdl/dcpe_dc_stage.sv
hdl/dcpe_emph_stage.sv
hdl/dcpe_gain_stage.sv
hdl/audio_dc_preemphasis_gate_chain.sv
hdl/dcpe_checker.sv
test/audio_dc_preemphasis_gate_chain_tb.sv
